// File: rtl/four_channel_current_filter_defines.svh
// ----------------------------------------------------------------------------
// four_channel_current_filter_defines
// Assertion macros used by the current filter control RTL.
// ----------------------------------------------------------------------------
`ifndef FOUR_CHANNEL_CURRENT_FILTER_DEFINES_SVH
`define FOUR_CHANNEL_CURRENT_FILTER_DEFINES_SVH
`ifndef ASSERT_OFF
// plain property on clk, disabled while arst_n is low
`define FCCF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// same-cycle implication
`define FCCF_ASSERT_IMPL(label, ante, cons, msg) \
	`FCCF_ASSERT(label, ante |-> cons, msg)
// next-cycle implication
`define FCCF_ASSERT_NEXT(label, ante, cons, msg) \
	`FCCF_ASSERT(label, ante |=> cons, msg)
`else
`define FCCF_ASSERT(label, prop, msg)
`define FCCF_ASSERT_IMPL(label, ante, cons, msg)
`define FCCF_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: rtl/fccf_pkg.sv
// ----------------------------------------------------------------------------
// fccf_pkg
// Constants, register codes and control structs of the current filter.
// ----------------------------------------------------------------------------
package fccf_pkg;

	localparam int NCH       = 4;
	// window length, a power of two so the mean is a plain shift
	localparam int WINDOW    = 4;
	localparam int WIN_LOG2  = $clog2(WINDOW);
	localparam int WIN_IDX_W = (WINDOW > 1) ? WIN_LOG2 : 1;
	localparam int CH_W      = $clog2(NCH);

	localparam int RAW_W     = 12;
	localparam int SUM_W     = RAW_W + WIN_LOG2;
	localparam int SCALE_W   = 24;
	localparam int ALPHA_W   = 17;
	localparam int AMP_W     = 28;
	localparam int PROD_W    = RAW_W + SCALE_W;
	localparam int FRAC_SHIFT = 8;
	localparam int DIFF_W    = AMP_W + 1;
	localparam int MPROD_W   = ALPHA_W + 1 + DIFF_W;
	localparam int EMA_SHIFT = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;
	localparam logic [SCALE_W-1:0] SCALE_RST = 24'd27041;
	localparam logic signed [MPROD_W-1:0] EMA_ROUND = MPROD_W'(32768);

	localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd2;

	typedef struct packed {
		logic            capture;
		logic            issue;
		logic [CH_W-1:0] ch;
		logic            load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic wb_last;
	} dp_status_t;

	typedef struct packed {
		logic [SCALE_W-1:0] scale;
		logic [ALPHA_W-1:0] alpha;
		logic               bypass;
	} cfg_state_t;

endpackage

// File: rtl/fccf_if.sv
// ----------------------------------------------------------------------------
// fccf_if
// Valid/ready channel interfaces: sample frames, result words, config writes.
// ----------------------------------------------------------------------------
interface fccf_sample_if import fccf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] raw_ch0;
	logic [RAW_W-1:0] raw_ch1;
	logic [RAW_W-1:0] raw_ch2;
	logic [RAW_W-1:0] raw_ch3;
	modport source (output valid, raw_ch0, raw_ch1, raw_ch2, raw_ch3, input ready);
	modport sink (input valid, raw_ch0, raw_ch1, raw_ch2, raw_ch3, output ready);
endinterface

interface fccf_result_if import fccf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [AMP_W-1:0] amp_ch0;
	logic [AMP_W-1:0] amp_ch1;
	logic [AMP_W-1:0] amp_ch2;
	logic [AMP_W-1:0] amp_ch3;
	logic [AMP_W-1:0] filt_ch0;
	logic [AMP_W-1:0] filt_ch1;
	logic [AMP_W-1:0] filt_ch2;
	logic [AMP_W-1:0] filt_ch3;
	modport source (output valid, amp_ch0, amp_ch1, amp_ch2, amp_ch3,
		filt_ch0, filt_ch1, filt_ch2, filt_ch3, input ready);
	modport sink (input valid, amp_ch0, amp_ch1, amp_ch2, amp_ch3,
		filt_ch0, filt_ch1, filt_ch2, filt_ch3, output ready);
endinterface

interface fccf_cfg_if import fccf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/fccf_cfg.sv
// ----------------------------------------------------------------------------
// fccf_cfg
// Configuration registers and the primed flag of the low-pass filter.
// ----------------------------------------------------------------------------
module fccf_cfg import fccf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	fccf_cfg_if.sink   cfg,
	input  logic       set_primed,
	output cfg_state_t cfg_st
);

	logic [SCALE_W-1:0] scale_q;
	logic [ALPHA_W-1:0] alpha_q;
	logic               enable_q;
	logic               primed_q;
	logic [ALPHA_W-1:0] alpha_wr;

	assign cfg.ready = 1'b1;

	// alpha above one saturates to pass-through
	always_comb begin
		alpha_wr = cfg.data[ALPHA_W-1:0];
		if (alpha_wr > ALPHA_ONE) begin
			alpha_wr = ALPHA_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= SCALE_RST;
			alpha_q  <= ALPHA_ONE;
			enable_q <= 1'b0;
			primed_q <= 1'b0;
		end else begin
			if (set_primed) begin
				primed_q <= 1'b1;
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_SCALE: begin
						scale_q <= cfg.data[SCALE_W-1:0];
					end
					REG_ENABLE: begin
						enable_q <= cfg.data[0];
						if (!cfg.data[0]) begin
							alpha_q  <= ALPHA_ONE;
							primed_q <= 1'b0;
						end
					end
					REG_ALPHA: begin
						alpha_q <= alpha_wr;
						if (alpha_wr < ALPHA_ONE) begin
							enable_q <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign cfg_st.scale  = scale_q;
	assign cfg_st.alpha  = alpha_q;
	assign cfg_st.bypass = !enable_q || (alpha_q >= ALPHA_ONE) || !primed_q;

endmodule

// File: rtl/fccf_datapath.sv
// ----------------------------------------------------------------------------
// fccf_datapath
// Per-channel window sum, scale multiply and EMA update, one channel a cycle.
// ----------------------------------------------------------------------------
module fccf_datapath import fccf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  ctrl_cmd_t        cmd,
	input  cfg_state_t       cfg_st,
	input  logic [RAW_W-1:0] raw [NCH],
	output dp_status_t       status,
	output logic [AMP_W-1:0] amp [NCH],
	output logic [AMP_W-1:0] filt [NCH]
);

	logic [RAW_W-1:0]     raw_q [NCH];
	logic                 bypass_q;
	logic [RAW_W-1:0]     win_q [NCH][WINDOW];
	logic [SUM_W-1:0]     sum_q [NCH];
	logic [WIN_IDX_W-1:0] slot_q;
	logic [AMP_W-1:0]     y_q [NCH];
	logic [AMP_W-1:0]     res_amp_q [NCH];
	logic [AMP_W-1:0]     res_filt_q [NCH];
	logic [AMP_W-1:0]     out_amp_q [NCH];
	logic [AMP_W-1:0]     out_filt_q [NCH];

	logic                       v_s1, v_s2;
	logic [CH_W-1:0]            ch_s1, ch_s2;
	logic [PROD_W-1:0]          prod_s1;
	logic [AMP_W-1:0]           amp_s2;
	logic signed [MPROD_W-1:0]  mprod_s2;

	logic [RAW_W-1:0]          new_smp, old_smp;
	logic [SUM_W-1:0]          new_sum;
	logic [RAW_W-1:0]          mean;
	logic [AMP_W-1:0]          amp_b;
	logic signed [DIFF_W-1:0]  diff_b;
	logic signed [MPROD_W-1:0] step_c;
	logic signed [MPROD_W-1:0] ysum_c;
	logic [AMP_W-1:0]          ynew_c;

	// stage 1: ring update, running sum, mean times scale
	assign new_smp = raw_q[cmd.ch];
	assign old_smp = win_q[cmd.ch][slot_q];
	assign new_sum = sum_q[cmd.ch] + SUM_W'(new_smp) - SUM_W'(old_smp);
	assign mean    = RAW_W'(new_sum >> WIN_LOG2);

	// stage 2: truncate to Q12.16, alpha times difference
	assign amp_b  = prod_s1[FRAC_SHIFT +: AMP_W];
	assign diff_b = $signed({1'b0, amp_b}) - $signed({1'b0, y_q[ch_s1]});

	// stage 3: round half up, floor shift, accumulate
	assign step_c = (mprod_s2 + EMA_ROUND) >>> EMA_SHIFT;
	assign ysum_c = $signed({{(MPROD_W-AMP_W){1'b0}}, y_q[ch_s2]}) + step_c;
	assign ynew_c = bypass_q ? amp_s2 : ysum_c[AMP_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			slot_q <= '0;
			for (int c = 0; c < NCH; c++) begin
				sum_q[c] <= '0;
				y_q[c]   <= '0;
				for (int i = 0; i < WINDOW; i++) begin
					win_q[c][i] <= '0;
				end
			end
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			if (cmd.issue) begin
				win_q[cmd.ch][slot_q] <= new_smp;
				sum_q[cmd.ch]         <= new_sum;
				if (cmd.ch == CH_W'(NCH - 1)) begin
					slot_q <= (slot_q == WIN_IDX_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
				end
			end
			if (v_s2) begin
				y_q[ch_s2] <= ynew_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			raw_q    <= raw;
			bypass_q <= cfg_st.bypass;
		end
		if (cmd.issue) begin
			prod_s1 <= mean * cfg_st.scale;
			ch_s1   <= cmd.ch;
		end
		if (v_s1) begin
			amp_s2   <= amp_b;
			ch_s2    <= ch_s1;
			mprod_s2 <= $signed({1'b0, cfg_st.alpha}) * diff_b;
		end
		if (v_s2) begin
			res_amp_q[ch_s2]  <= amp_s2;
			res_filt_q[ch_s2] <= ynew_c;
		end
		if (cmd.load) begin
			out_amp_q  <= res_amp_q;
			out_filt_q <= res_filt_q;
		end
	end

	assign status.wb_last = v_s2 && (ch_s2 == CH_W'(NCH - 1));
	assign amp  = out_amp_q;
	assign filt = out_filt_q;

endmodule

// File: rtl/fccf_ctrl.sv
// ----------------------------------------------------------------------------
// fccf_ctrl
// Frame sequencer: capture, channel issue, pipeline drain, result hand-off.
// ----------------------------------------------------------------------------
`include "four_channel_current_filter_defines.svh"

module fccf_ctrl import fccf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sample_valid,
	output logic       sample_ready,
	output logic       result_valid,
	input  logic       result_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_ISSUE = 4'b0010,
		S_DRAIN = 4'b0100,
		S_LOAD  = 4'b1000
	} state_t;

	state_t          state_q, state_d;
	logic [CH_W-1:0] cnt_q;
	logic            out_v_q;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		sample_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (sample_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_ISSUE;
				end
			end
			S_ISSUE: begin
				cmd.issue = 1'b1;
				cmd.ch    = cnt_q;
				if (cnt_q == CH_W'(NCH - 1)) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (status.wb_last) begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				// wait for the output word to free up
				if (!out_v_q || result_ready) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_ISSUE && cnt_q != CH_W'(NCH - 1)) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (cmd.load) begin
				out_v_q <= 1'b1;
			end else if (result_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_v_q;

	`FCCF_ASSERT_NEXT(a_load_holds, state_q == S_LOAD && out_v_q && !result_ready, state_q == S_LOAD, "result word overwritten before taken")
	`FCCF_ASSERT_IMPL(a_wb_in_drain, status.wb_last, state_q == S_DRAIN, "last channel written back outside drain")
	`FCCF_ASSERT_NEXT(a_load_valid, cmd.load, out_v_q, "loaded result word not flagged valid")

endmodule

// File: rtl/four_channel_current_filter.sv
// ----------------------------------------------------------------------------
// four_channel_current_filter
// Window mean, amps scaling and EMA low-pass for four ADC current channels.
// ----------------------------------------------------------------------------
// channel  dir  word
// sample   in   raw_ch0..raw_ch3, 12-bit ADC counts
// result   out  amp_ch0..3 and filt_ch0..3, Q12.16 amps
// cfg      in   index 0 scale_per_lsb, 1 lpf_enable, 2 lpf_alpha
//
// a frame goes from accept to result word in order: a capture, an issue of
// each channel in turn through the shared multiply path, a drain of the
// EMA stages and a load into the output register.
// a new frame is accepted while the previous result word waits; the load
// stalls until that word is taken. cfg is always ready.
// arst_n clears windows, sums, filter state, primed flag and registers.
// ----------------------------------------------------------------------------
module four_channel_current_filter import fccf_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	fccf_sample_if.sink    sample,
	fccf_result_if.source  result,
	fccf_cfg_if.sink       cfg
);

	ctrl_cmd_t        cmd;
	dp_status_t       status;
	cfg_state_t       cfg_st;
	logic [RAW_W-1:0] raw [NCH];
	logic [AMP_W-1:0] amp [NCH];
	logic [AMP_W-1:0] filt [NCH];

	assign raw[0] = sample.raw_ch0;
	assign raw[1] = sample.raw_ch1;
	assign raw[2] = sample.raw_ch2;
	assign raw[3] = sample.raw_ch3;

	fccf_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.set_primed (cmd.capture),
		.cfg_st     (cfg_st)
	);

	fccf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample.valid),
		.sample_ready (sample.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.status       (status),
		.cmd          (cmd)
	);

	fccf_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg_st (cfg_st),
		.raw    (raw),
		.status (status),
		.amp    (amp),
		.filt   (filt)
	);

	assign result.amp_ch0  = amp[0];
	assign result.amp_ch1  = amp[1];
	assign result.amp_ch2  = amp[2];
	assign result.amp_ch3  = amp[3];
	assign result.filt_ch0 = filt[0];
	assign result.filt_ch1 = filt[1];
	assign result.filt_ch2 = filt[2];
	assign result.filt_ch3 = filt[3];

endmodule

// File: test/fccf_checker.sv
// ----------------------------------------------------------------------------
// fccf_checker
// Watches the sample, result and cfg channels of the current filter, keeps
// its own window mean, amps scaling and EMA state, and compares every result
// word with the word predicted for the oldest outstanding frame.
// ----------------------------------------------------------------------------
module fccf_checker import fccf_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	fccf_sample_if sample,
	fccf_result_if result,
	fccf_cfg_if    cfg,
	output int     n_pending,
	output int     n_errors
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [NCH-1:0][AMP_W-1:0] amp;
		logic [NCH-1:0][AMP_W-1:0] filt;
	} current_word_t;

	logic [SCALE_W-1:0] scale_q;
	logic               lpf_on;
	logic [ALPHA_W-1:0] alpha_q;
	logic [RAW_W-1:0]   history [NCH][WINDOW];
	int unsigned        slot;
	logic [AMP_W-1:0]   filt_state [NCH];
	logic               primed_q;
	current_word_t      expected_words [$];
	int                 mismatches = 0;

	function automatic void clear_filter_state();
		scale_q = SCALE_RST;
		lpf_on = 1'b0;
		alpha_q = ALPHA_ONE;
		for (int c = 0; c < NCH; c++) begin
			for (int i = 0; i < WINDOW; i++)
				history[c][i] = '0;
			filt_state[c] = '0;
		end
		slot = 0;
		primed_q = 1'b0;
		expected_words.delete();
	endfunction

	function automatic void write_register(logic [CFG_IDX_W-1:0] idx,
		logic [CFG_DATA_W-1:0] value);
		logic [ALPHA_W-1:0] a;
		case (idx)
			REG_SCALE: scale_q = value[SCALE_W-1:0];
			REG_ENABLE: begin
				lpf_on = value[0];
				if (!value[0]) begin
					alpha_q = ALPHA_ONE;
					primed_q = 1'b0;
				end
			end
			REG_ALPHA: begin
				a = value[ALPHA_W-1:0];
				if (a > ALPHA_ONE)
					a = ALPHA_ONE;
				alpha_q = a;
				if (a < ALPHA_ONE)
					lpf_on = 1'b1;
			end
			default: ;
		endcase
	endfunction

	// y + floor((alpha * (x - y) + 32768) / 65536), all signed
	function automatic logic [AMP_W-1:0] ema_step(logic [AMP_W-1:0] y,
		logic [AMP_W-1:0] x, logic [ALPHA_W-1:0] a);
		longint d;
		longint t;
		d = longint'(x) - longint'(y);
		t = longint'(a) * d + 64'sd32768;
		return AMP_W'(longint'(y) + (t >>> EMA_SHIFT));
	endfunction

	function automatic current_word_t filter_frame(logic [NCH-1:0][RAW_W-1:0] raw);
		current_word_t w;
		int            sum;
		longint        prod;
		logic          bypass;
		for (int c = 0; c < NCH; c++)
			history[c][slot] = raw[c];
		slot = (slot + 1) % WINDOW;
		for (int c = 0; c < NCH; c++) begin
			sum = 0;
			for (int i = 0; i < WINDOW; i++)
				sum += int'(history[c][i]);
			prod = longint'(sum / WINDOW) * longint'(scale_q);
			w.amp[c] = AMP_W'(prod >> FRAC_SHIFT);
		end
		bypass = !lpf_on || alpha_q >= ALPHA_ONE || !primed_q;
		for (int c = 0; c < NCH; c++) begin
			filt_state[c] = bypass ? w.amp[c] : ema_step(filt_state[c], w.amp[c], alpha_q);
			w.filt[c] = filt_state[c];
		end
		if (bypass)
			primed_q = 1'b1;
		return w;
	endfunction

	function automatic void report_field(string field, int c, logic [AMP_W-1:0] want,
		logic [AMP_W-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s_ch%0d mismatch, expected 0x%07h, got 0x%07h",
				$realtime, field, c, want, got);
	endfunction

	function automatic void check_word(current_word_t got);
		current_word_t want;
		if (expected_words.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result word with no frame outstanding", $realtime);
			return;
		end
		want = expected_words.pop_front();
		for (int c = 0; c < NCH; c++) begin
			if (got.amp[c] !== want.amp[c])
				report_field("amp", c, want.amp[c], got.amp[c]);
			if (got.filt[c] !== want.filt[c])
				report_field("filt", c, want.filt[c], got.filt[c]);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		current_word_t got;
		if (!arst_n) begin
			clear_filter_state();
		end else begin
			if (cfg.valid && cfg.ready)
				write_register(cfg.index, cfg.data);
			if (sample.valid && sample.ready)
				expected_words.push_back(filter_frame({sample.raw_ch3, sample.raw_ch2,
					sample.raw_ch1, sample.raw_ch0}));
			if (result.valid && result.ready) begin
				got.amp = {result.amp_ch3, result.amp_ch2, result.amp_ch1, result.amp_ch0};
				got.filt = {result.filt_ch3, result.filt_ch2, result.filt_ch1,
					result.filt_ch0};
				check_word(got);
			end
		end
		n_pending <= expected_words.size();
		n_errors <= mismatches;
	end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives sample frames and register writes into the current filter under
// random source gaps and result back-pressure; the checker beside the block
// predicts each result word and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import fccf_pkg::*;

	localparam int CYCLE_LIMIT  = 800_000;
	localparam int DRAIN        = 16;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_FRAMES = 250;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef logic [NCH-1:0][RAW_W-1:0] frame_t;

	logic   clk = 1'b0;
	logic   arst_n;
	int     flow_mode = 0;
	int     stall_left = 0;
	int     cycle_count = 0;
	int     n_pending;
	int     n_errors;
	frame_t last_frame = '0;

	fccf_sample_if sample_ch ();
	fccf_result_if result_ch ();
	fccf_cfg_if    cfg_ch ();

	four_channel_current_filter i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	fccf_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg       (cfg_ch),
		.n_pending (n_pending),
		.n_errors  (n_errors)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[four_channel_current_filter] ERROR");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// result back-pressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (flow_mode != 0 && $urandom_range(0, 3) == 0) begin
			result_ch.ready <= 1'b0;
			stall_left <= pick_gap();
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	task automatic send_frame(input frame_t raw);
		int gap;
		gap = (flow_mode == 0) ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			sample_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		sample_ch.valid <= 1'b1;
		sample_ch.raw_ch0 <= raw[0];
		sample_ch.raw_ch1 <= raw[1];
		sample_ch.raw_ch2 <= raw[2];
		sample_ch.raw_ch3 <= raw[3];
		last_frame = raw;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// no frame in flight and the pipeline drained
	task automatic settle();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (n_pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	function automatic logic [RAW_W-1:0] random_sample(logic [RAW_W-1:0] prev);
		int n;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return prev;
			3, 4: begin
				n = int'(prev) + $urandom_range(0, 64) - 32;
				if (n < 0)
					n = 0;
				if (n > 4095)
					n = 4095;
				return RAW_W'(n);
			end
			default: return RAW_W'($urandom_range(0, 4095));
		endcase
	endfunction

	task automatic random_setup();
		logic [CFG_DATA_W-1:0] v;
		logic [ALPHA_W-1:0]    a;
		v = CFG_DATA_W'($urandom());
		case ($urandom_range(0, 3))
			0: v = '0;
			1: v = '1;
			2: v = CFG_DATA_W'($urandom_range(1000, 200000));
			default: ;
		endcase
		write_reg(REG_SCALE, v);
		if ($urandom_range(0, 2) == 0) begin
			v = CFG_DATA_W'($urandom());
			v[0] = 1'b0;
			write_reg(REG_ENABLE, v);
		end
		case ($urandom_range(0, 7))
			0: a = '0;
			1: a = 17'd1;
			2: a = 17'h0FFFF;
			3: a = ALPHA_ONE;
			4: a = ALPHA_ONE + 17'($urandom_range(1, 65535));
			5: a = 17'($urandom_range(1, 4095));
			default: a = 17'($urandom_range(0, 65535));
		endcase
		v = CFG_DATA_W'($urandom());
		v[ALPHA_W-1:0] = a;
		if ($urandom_range(0, 4) != 0)
			write_reg(REG_ALPHA, v);
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_ENABLE, CFG_DATA_W'($urandom()));
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
	endtask

	initial begin
		frame_t f;
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.raw_ch0 = '0;
		sample_ch.raw_ch1 = '0;
		sample_ch.raw_ch2 = '0;
		sample_ch.raw_ch3 = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: filter bypassed, default scale
		flow_mode = 1;
		send_frame({4{12'h000}});
		repeat (4) send_frame({4{12'hFFF}});
		send_frame({12'hAAA, 12'h555, 12'h000, 12'hFFF});
		send_frame({12'h555, 12'hAAA, 12'hFFF, 12'h000});
		settle();

		// full scale, filter off then on: first filtered word passes through
		write_reg(REG_SCALE, 24'hFFFFFF);
		write_reg(REG_ENABLE, 24'hFFFFFE);
		write_reg(REG_ALPHA, 24'hFE0001);
		repeat (2) send_frame({4{12'hFFF}});
		repeat (2) send_frame({4{12'h000}});
		send_frame({12'h001, 12'hFFE, 12'h800, 12'h7FF});
		settle();

		// alpha zero holds the filter state
		write_reg(REG_ALPHA, 24'h000000);
		send_frame({4{12'hFFF}});
		send_frame({12'hFFF, 12'h000, 12'hFFF, 12'h000});
		send_frame({4{12'h123}});
		settle();

		write_reg(REG_ALPHA, 24'h00FFFF);
		send_frame({4{12'h000}});
		send_frame({4{12'hFFF}});
		send_frame({12'h000, 12'hFFF, 12'h000, 12'hFFF});
		settle();

		// alpha above one saturates to pass-through
		write_reg(REG_ALPHA, 24'h01FFFF);
		send_frame({4{12'h800}});
		settle();
		write_reg(REG_ALPHA, 24'h010000);
		send_frame({4{12'h7FF}});
		settle();

		// unknown index is ignored, zero scale
		write_reg(REG_UNUSED, 24'h5A5A5A);
		write_reg(REG_ENABLE, 24'h000001);
		write_reg(REG_SCALE, 24'h000000);
		send_frame({4{12'hFFF}});
		send_frame({12'hAAA, 12'h555, 12'hAAA, 12'h555});
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			flow_mode = p % 3;
			random_setup();
			repeat (PHASE_FRAMES) begin
				for (int c = 0; c < NCH; c++)
					f[c] = random_sample(last_frame[c]);
				send_frame(f);
			end
			settle();
		end

		if (n_errors == 0) begin
			$display("[four_channel_current_filter] OK");
		end else begin
			$display("[four_channel_current_filter] ERROR");
		end
		$finish;
	end

endmodule
